### rtl/skt_pkg.sv
// Shared constants and types for the sorted key table.
// Depends on nothing; used by the channel interfaces and the top level.
package skt_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_CHARS = 8;

    localparam int KEY_W    = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    // Short keys keep only their leading characters.
    localparam logic [KEY_W-1:0] KEY_MASK = ~(KEY_W'(0)) << (8 * (8 - KEY_CHARS));

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_SEARCH = 2'd0;
    localparam func_t FUNC_INSERT = 2'd1;
    localparam func_t FUNC_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_RESULT
    } state_t;

endpackage

### rtl/skt_req_if.sv
// Request channel of the sorted key table: operation code and key.
// Depends on skt_pkg.
interface skt_req_if;
    logic                      valid;
    logic                      ready;
    logic [skt_pkg::FUNC_W-1:0] func;
    logic [skt_pkg::KEY_W-1:0]  key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

### rtl/skt_rsp_if.sv
// Response channel of the sorted key table: status, position and count.
// Depends on skt_pkg.
interface skt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [skt_pkg::STATUS_W-1:0] status;
    logic [skt_pkg::IDX_W-1:0]    position;
    logic [skt_pkg::CNT_W-1:0]    entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

### rtl/sorted_key_table_unit.sv
// Sorted key table: up to 64 distinct 64-bit keys in ascending order.
// Depends on skt_pkg, skt_req_if and skt_rsp_if.
//
// Usage:
//   req carries one word per operation: func (0 search, 1 insert, 2 remove)
//   and key. rsp returns one word per request: status, position and the
//   entry count after the operation.
//   The keys live in a synchronous RAM with a registered read. A request
//   runs a binary search of P probes, each a probe and a compare step, with
//   P <= ceil(log2(count+1)) and at most 7, then inserts or removes by moving
//   one entry per cycle through the RAM read and write ports. req.ready is
//   high only in idle, so a new request is accepted only once the previous
//   one has put its word into the output register. If rsp stalls, the
//   finished word holds in the output register; the next request is still
//   accepted and worked, and its word waits until the previous one is taken.
//   Reset clears the entry count and the handshake state; the RAM is not
//   cleared, since only entries below the count are read.
module sorted_key_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    skt_req_if.sink     req,
    skt_rsp_if.source   rsp
);

    localparam int IDX_W = skt_pkg::IDX_W;
    localparam int CNT_W = skt_pkg::CNT_W;
    localparam int KEY_W = skt_pkg::KEY_W;

    skt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg, count_next;
    skt_pkg::func_t         func_reg, func_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    logic [IDX_W-1:0]       mid_reg, mid_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_addr_reg, pend_addr_next;
    skt_pkg::status_t       res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_pos_reg, res_pos_next;

    logic                   out_valid_reg, out_valid_next;
    skt_pkg::status_t       out_status_reg, out_status_next;
    logic [IDX_W-1:0]       out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;

    logic [KEY_W-1:0]       mem [skt_pkg::DEPTH];
    logic [KEY_W-1:0]       rd_data_reg;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [KEY_W-1:0]       mem_wdata;

    logic [CNT_W:0]         mid_sum;
    logic                   shift_done;
    logic                   out_free;

    assign mid_sum    = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
    assign shift_done = (left_reg == '0) && !pend_reg;
    assign out_free   = !out_valid_reg || rsp.ready;

    // Key RAM: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        hit_reg        <= hit_next;
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = skt_pkg::S_PROBE;
                end
            end
            skt_pkg::S_PROBE:
            begin
                state_next = (lo_reg < hi_reg) ? skt_pkg::S_CMP : skt_pkg::S_DECIDE;
            end
            skt_pkg::S_CMP:
            begin
                state_next = skt_pkg::S_PROBE;
            end
            skt_pkg::S_DECIDE:
            begin
                if (func_reg == skt_pkg::FUNC_INSERT && !hit_reg
                    && count_reg != CNT_W'(skt_pkg::DEPTH))
                begin
                    state_next = skt_pkg::S_SHIFT;
                end
                else if (func_reg == skt_pkg::FUNC_REMOVE && hit_reg)
                begin
                    state_next = skt_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = skt_pkg::S_RESULT;
                end
            end
            skt_pkg::S_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = skt_pkg::S_RESULT;
                end
            end
            skt_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshake and RAM control.
    always_comb
    begin
        req.ready = 1'b0;
        mem_raddr = mid_reg;
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = rd_data_reg;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            skt_pkg::S_PROBE:
            begin
                mem_raddr = mid_sum[IDX_W-1:0];
            end
            skt_pkg::S_SHIFT:
            begin
                mem_raddr = ptr_reg;
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                else if (left_reg == '0 && func_reg == skt_pkg::FUNC_INSERT)
                begin
                    // Moves finished: drop the new key into its slot.
                    mem_we    = 1'b1;
                    mem_waddr = lo_reg[IDX_W-1:0];
                    mem_wdata = key_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        count_next      = count_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        hit_next        = hit_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                func_next = req.func;
                key_next  = req.key & skt_pkg::KEY_MASK;
                lo_next   = '0;
                hi_next   = count_reg;
                hit_next  = 1'b0;
                pend_next = 1'b0;
            end
            skt_pkg::S_PROBE:
            begin
                mid_next = mid_sum[IDX_W-1:0];
            end
            skt_pkg::S_CMP:
            begin
                if (rd_data_reg < key_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                if (rd_data_reg == key_reg)
                begin
                    hit_next = 1'b1;
                end
            end
            skt_pkg::S_DECIDE:
            begin
                res_pos_next = '0;
                pend_next    = 1'b0;
                if (func_reg == skt_pkg::FUNC_INSERT)
                begin
                    if (hit_reg)
                    begin
                        res_status_next = skt_pkg::ST_DUPLICATE;
                    end
                    else if (count_reg == CNT_W'(skt_pkg::DEPTH))
                    begin
                        res_status_next = skt_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_status_next = skt_pkg::ST_INSERTED;
                        res_pos_next    = lo_reg[IDX_W-1:0];
                        ptr_next        = IDX_W'(count_reg - CNT_W'(1));
                        left_next       = count_reg - lo_reg;
                    end
                end
                else if (func_reg == skt_pkg::FUNC_REMOVE)
                begin
                    if (hit_reg)
                    begin
                        res_status_next = skt_pkg::ST_REMOVED;
                        res_pos_next    = lo_reg[IDX_W-1:0];
                        ptr_next        = IDX_W'(lo_reg + CNT_W'(1));
                        left_next       = count_reg - lo_reg - CNT_W'(1);
                    end
                    else
                    begin
                        res_status_next = skt_pkg::ST_ABSENT;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        res_status_next = skt_pkg::ST_FOUND;
                        res_pos_next    = lo_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        res_status_next = skt_pkg::ST_ABSENT;
                    end
                end
            end
            skt_pkg::S_SHIFT:
            begin
                // Read one entry per cycle; its data lands one place over
                // on the following cycle.
                if (left_reg != '0)
                begin
                    pend_next = 1'b1;
                    left_next = left_reg - CNT_W'(1);
                    if (func_reg == skt_pkg::FUNC_INSERT)
                    begin
                        pend_addr_next = ptr_reg + IDX_W'(1);
                        ptr_next       = ptr_reg - IDX_W'(1);
                    end
                    else
                    begin
                        pend_addr_next = ptr_reg - IDX_W'(1);
                        ptr_next       = ptr_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (shift_done)
                begin
                    if (func_reg == skt_pkg::FUNC_INSERT)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            skt_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_count_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.entry_count = out_count_reg;

endmodule
